/* design/fcd_pkg.sv */
package fcd_pkg;

   localparam int VALUE_W = 8;
   localparam int POS_W   = 10;
   localparam int CFG_W   = 11;

   typedef enum logic {
      CMD_CELL  = 1'b0,
      CMD_FLUSH = 1'b1
   } command_type;

   typedef enum logic {
      REG_MAP_WIDTH  = 1'b0,
      REG_MAP_HEIGHT = 1'b1
   } reg_index_type;

   typedef logic signed [VALUE_W-1:0] cell_value_type;
   typedef logic [POS_W-1:0]          pos_type;
   typedef logic [CFG_W-1:0]          cfg_data_type;

   localparam cell_value_type CELL_UNKNOWN = -8'sd1;
   localparam cell_value_type CELL_FREE    = 8'sd0;

   // per-cell class kept in the line stores and the window
   typedef enum logic [1:0] {
      CLS_OTHER   = 2'd0,
      CLS_FREE    = 2'd1,
      CLS_UNKNOWN = 2'd2
   } cls_type;

   // one window column, index 0 top, 1 middle, 2 bottom
   typedef logic [2:0][1:0] cls_col_type;

   typedef struct packed {
      pos_type col;
      pos_type row;
      logic    frontier;
      logic    last;
   } verdict_type;

endpackage

/* design/fcd_channels.sv */
interface fcd_req_if;
   import fcd_pkg::*;
   logic           valid;
   logic           ready;
   command_type    command;
   cell_value_type cell_value;
   modport source (output valid, command, cell_value, input ready);
   modport sink   (input valid, command, cell_value, output ready);
endinterface

interface fcd_rsp_if;
   import fcd_pkg::*;
   logic    valid;
   logic    ready;
   pos_type cell_col;
   pos_type cell_row;
   logic    is_frontier;
   logic    last_cell;
   modport source (output valid, cell_col, cell_row, is_frontier, last_cell, input ready);
   modport sink   (input valid, cell_col, cell_row, is_frontier, last_cell, output ready);
endinterface

interface fcd_csr_if;
   import fcd_pkg::*;
   logic          valid;
   logic          ready;
   reg_index_type index;
   cfg_data_type  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* design/frontier_cell_detector.sv */
// channel   dir  handshake     payload
// req_bus   in   valid/ready   command, cell_value
// rsp_bus   out  valid/ready   cell_col, cell_row, is_frontier, last_cell
// csr_bus   in   valid/ready   index, data (0 map_width, 1 map_height)
//
// One request per clock while req_ready is high. Each line store is read at accept
// and written back the next cycle (one read and one write port each); a verdict is
// formed from the stage-1 register and the window, then queued for rsp_bus.
// A 4-entry result queue absorbs rsp stalls; req_ready drops once queued plus
// in-flight verdicts reach four.
// Synchronous reset clears position, window and queue; line stores are not cleared.
// A csr write restarts the stream.
module frontier_cell_detector #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input logic        clock,
   input logic        reset,
   fcd_req_if.sink    req_bus,
   fcd_rsp_if.source  rsp_bus,
   fcd_csr_if.sink    csr_bus
);
   import fcd_pkg::*;

   localparam int AW     = $clog2(MAX_WIDTH);
   localparam int CW     = $clog2(MAX_WIDTH + 1);
   localparam int HW     = $clog2(MAX_HEIGHT + 1);
   localparam int RW     = $clog2(MAX_HEIGHT + 2);
   localparam int W_RST  = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
   localparam int H_RST  = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;
   localparam int QDEPTH = 4;
   localparam int QPW    = $clog2(QDEPTH);
   localparam int QCW    = $clog2(QDEPTH + 2);

   typedef struct packed {
      logic [AW-1:0] addr;
      cls_type       cls;
      logic          judged;
      logic [RW-1:0] tr;
      logic [AW-1:0] tc;
      logic          left_ok;
      logic          right_ok;
      logic          top_ok;
      logic          bot_ok;
      logic          last;
   } stage_type;

   function automatic logic [CW-1:0] eff_width(cfg_data_type v);
      if (v == '0) return CW'(1);
      if (32'(v) > 32'(MAX_WIDTH)) return CW'(MAX_WIDTH);
      return CW'(v);
   endfunction

   function automatic logic [HW-1:0] eff_height(cfg_data_type v);
      if (v == '0) return HW'(1);
      if (32'(v) > 32'(MAX_HEIGHT)) return HW'(MAX_HEIGHT);
      return HW'(v);
   endfunction

   logic [1:0] upper_mem  [MAX_WIDTH];
   logic [1:0] middle_mem [MAX_WIDTH];

   logic [CW-1:0]  width_ff, width_in;
   logic [HW-1:0]  height_ff, height_in;
   logic [AW-1:0]  col_ff, col_in;
   logic [RW-1:0]  row_ff, row_in;
   logic           s1_valid_ff, s1_valid_in;
   stage_type      s1_ff, s1_in;
   logic           fwd_ff, fwd_in;
   logic [1:0]     fwd_up_ff, fwd_mid_ff;
   logic [1:0]     up_rd_ff, mid_rd_ff;
   cls_col_type [1:0] win_ff, win_in;

   verdict_type    queue_ff [QDEPTH];
   logic [QPW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0] cnt_ff, cnt_in;

   logic           req_acc, csr_acc, draining, issue, push, pop, hit;
   logic [1:0]     up_val, mid_val;
   cls_col_type    new_col;
   verdict_type    verdict;

   assign req_acc = req_bus.valid && req_bus.ready;
   assign csr_acc = csr_bus.valid && csr_bus.ready;
   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = (cnt_ff + QCW'(s1_valid_ff)) < QCW'(QDEPTH);

   assign draining = row_ff >= RW'(height_ff);
   assign issue    = req_acc && !(req_bus.command == CMD_FLUSH && !draining);

   // request side: classify, position bookkeeping, judged-cell position, csr writes
   always_comb begin
      width_in    = width_ff;
      height_in   = height_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      s1_valid_in = issue;
      s1_in       = s1_ff;
      fwd_in      = issue && s1_valid_ff && (s1_ff.addr == col_ff);

      s1_in.addr = col_ff;
      if (draining) begin
         s1_in.cls = CLS_OTHER;
      end else if (req_bus.cell_value == CELL_UNKNOWN) begin
         s1_in.cls = CLS_UNKNOWN;
      end else if (req_bus.cell_value == CELL_FREE) begin
         s1_in.cls = CLS_FREE;
      end else begin
         s1_in.cls = CLS_OTHER;
      end

      if (col_ff != '0) begin
         s1_in.judged = row_ff != '0;
         s1_in.tr     = row_ff - RW'(1);
         s1_in.tc     = col_ff - AW'(1);
      end else begin
         s1_in.judged = row_ff >= RW'(2);
         s1_in.tr     = row_ff - RW'(2);
         s1_in.tc     = AW'(width_ff - CW'(1));
      end
      s1_in.left_ok  = s1_in.tc != '0;
      s1_in.right_ok = (CW'(s1_in.tc) + CW'(1)) < width_ff;
      s1_in.top_ok   = s1_in.tr != '0;
      s1_in.bot_ok   = (s1_in.tr + RW'(1)) < RW'(height_ff);
      s1_in.last     = s1_in.judged && !s1_in.right_ok && !s1_in.bot_ok;

      if (issue) begin
         if ((CW'(col_ff) + CW'(1)) >= width_ff) begin
            col_in = '0;
            row_in = row_ff + RW'(1);
         end else begin
            col_in = col_ff + AW'(1);
         end
         if (s1_in.last) begin
            col_in = '0;
            row_in = '0;
         end
      end

      if (csr_acc) begin
         unique case (csr_bus.index)
            REG_MAP_WIDTH:  width_in  = eff_width(csr_bus.data);
            REG_MAP_HEIGHT: height_in = eff_height(csr_bus.data);
            default: ;
         endcase
         col_in = '0;
         row_in = '0;
      end
   end

   // stage 1: line store data, window shift, verdict
   assign up_val  = fwd_ff ? fwd_up_ff  : up_rd_ff;
   assign mid_val = fwd_ff ? fwd_mid_ff : mid_rd_ff;

   always_comb begin
      logic row_ok;
      new_col[0] = up_val;
      new_col[1] = mid_val;
      new_col[2] = s1_ff.cls;
      hit = 1'b0;
      for (int i = 0; i < 3; i++) begin
         row_ok = (i == 0) ? s1_ff.top_ok : ((i == 2) ? s1_ff.bot_ok : 1'b1);
         if (row_ok && ((s1_ff.left_ok && win_ff[0][i] == CLS_UNKNOWN)
                        || win_ff[1][i] == CLS_UNKNOWN
                        || (s1_ff.right_ok && new_col[i] == CLS_UNKNOWN))) begin
            hit = 1'b1;
         end
      end
      verdict.col      = POS_W'(s1_ff.tc);
      verdict.row      = POS_W'(s1_ff.tr);
      verdict.frontier = (win_ff[1][1] == CLS_FREE) && hit;
      verdict.last     = s1_ff.last;

      win_in = win_ff;
      if (s1_valid_ff) begin
         win_in[0] = win_ff[1];
         win_in[1] = new_col;
         if (s1_ff.last) win_in = '0;
      end
      if (csr_acc) win_in = '0;
   end

   // result queue
   assign push = s1_valid_ff && s1_ff.judged;
   assign pop  = rsp_bus.valid && rsp_bus.ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPW'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + QCW'(push) - QCW'(pop);
   end

   assign rsp_bus.valid       = cnt_ff != '0;
   assign rsp_bus.cell_col    = queue_ff[rd_ptr_ff].col;
   assign rsp_bus.cell_row    = queue_ff[rd_ptr_ff].row;
   assign rsp_bus.is_frontier = queue_ff[rd_ptr_ff].frontier;
   assign rsp_bus.last_cell   = queue_ff[rd_ptr_ff].last;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= CW'(W_RST);
         height_ff   <= HW'(H_RST);
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         win_ff      <= '0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         cnt_ff      <= '0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
         win_ff      <= win_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         cnt_ff      <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_ff      <= s1_in;
         fwd_ff     <= fwd_in;
         fwd_up_ff  <= mid_val;
         fwd_mid_ff <= s1_ff.cls;
         up_rd_ff   <= upper_mem[col_ff];
         mid_rd_ff  <= middle_mem[col_ff];
      end
      if (push) queue_ff[wr_ptr_ff] <= verdict;
   end

   // line stores: read-modify-write, previous middle row moves up
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         upper_mem[s1_ff.addr]  <= mid_val;
         middle_mem[s1_ff.addr] <= s1_ff.cls;
      end
   end

endmodule

/* design/fcd_checker.sv */
module fcd_checker (
   input logic            clock,
   input logic            reset,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input fcd_pkg::pos_type rsp_cell_col,
   input fcd_pkg::pos_type rsp_cell_row,
   input logic            rsp_is_frontier,
   input logic            rsp_last_cell
);
   import fcd_pkg::*;

   // response held under backpressure
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_cell_col) && $stable(rsp_cell_row)
         && $stable(rsp_is_frontier) && $stable(rsp_last_cell))
      else $error("rsp payload changed while stalled");

   // result queue comes out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   // requests are only held off by pending results
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("req stalled with no pending result");

endmodule

bind frontier_cell_detector fcd_checker u_fcd_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_cell_col    (rsp_bus.cell_col),
   .rsp_cell_row    (rsp_bus.cell_row),
   .rsp_is_frontier (rsp_bus.is_frontier),
   .rsp_last_cell   (rsp_bus.last_cell)
);

/* sim/tb.sv */
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import fcd_pkg::*;

   localparam int unsigned MAX_DIM = 1024;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned RANDOM_REQUESTS = 300;

   class frontier_scoreboard;
      verdict_type  pending_verdicts[$];
      int unsigned  errors;
      int unsigned  checked;
      int unsigned  frontiers;
      cfg_data_type width_reg;
      cfg_data_type height_reg;
      cls_type      upper_line[MAX_DIM];
      cls_type      middle_line[MAX_DIM];
      cls_col_type  win_left;
      cls_col_type  win_mid;
      cls_col_type  win_right;
      int unsigned  col_pos;
      int unsigned  row_pos;

      function new();
         width_reg  = cfg_data_type'(MAX_DIM);
         height_reg = cfg_data_type'(MAX_DIM);
         foreach (upper_line[k]) begin
            upper_line[k]  = CLS_OTHER;
            middle_line[k] = CLS_OTHER;
         end
         restart();
      endfunction

      static function int unsigned clamp_dim(cfg_data_type v);
         if (v == 0) return 1;
         if (v > MAX_DIM) return MAX_DIM;
         return 32'(v);
      endfunction

      function void restart();
         win_left  = '0;
         win_mid   = '0;
         win_right = '0;
         col_pos   = 0;
         row_pos   = 0;
      endfunction

      function void apply_csr(reg_index_type idx, cfg_data_type d);
         if (idx == REG_MAP_WIDTH) width_reg = d;
         else height_reg = d;
         restart();
      endfunction

      function void accept_request(command_type cmd, cell_value_type val);
         int unsigned w, h, c, tr, tc;
         bit          draining, has_verdict, frontier, last;
         cls_type     cls, up, md;
         cls_col_type cols[3];
         verdict_type v;
         w = clamp_dim(width_reg);
         h = clamp_dim(height_reg);
         draining = row_pos >= h;
         if (cmd == CMD_FLUSH && !draining) return;
         cls = CLS_OTHER;
         if (!draining) begin
            if (val == CELL_UNKNOWN) cls = CLS_UNKNOWN;
            else if (val == CELL_FREE) cls = CLS_FREE;
         end
         c = (col_pos >= w) ? w - 1 : col_pos;
         up = upper_line[c];
         md = middle_line[c];
         upper_line[c]  = md;
         middle_line[c] = cls;
         win_left  = win_mid;
         win_mid   = win_right;
         win_right = {cls, md, up};
         tr = 0;
         tc = 0;
         if (c >= 1) begin
            has_verdict = row_pos >= 1;
            tr = row_pos - 1;
            tc = c - 1;
         end else begin
            has_verdict = row_pos >= 2;
            tr = row_pos - 2;
            tc = w - 1;
         end
         if (has_verdict && tr >= h) has_verdict = 0;
         c++;
         if (c >= w) begin
            c = 0;
            row_pos++;
         end
         col_pos = c;
         if (!has_verdict) return;
         frontier = 0;
         cols = '{win_left, win_mid, win_right};
         if (win_mid[1] == CLS_FREE) begin
            for (int j = 0; j < 3; j++) begin
               if (j == 0 && tc == 0) continue;
               if (j == 2 && tc + 1 >= w) continue;
               for (int i = 0; i < 3; i++) begin
                  if (i == 0 && tr == 0) continue;
                  if (i == 2 && tr + 1 >= h) continue;
                  if (cols[j][i] == CLS_UNKNOWN) frontier = 1;
               end
            end
         end
         last = (tr + 1 == h) && (tc + 1 == w);
         v.col      = pos_type'(tc);
         v.row      = pos_type'(tr);
         v.frontier = frontier;
         v.last     = last;
         pending_verdicts.insert(pending_verdicts.size(), v);
         if (last) restart();
      endfunction

      function void compare_verdict(verdict_type got);
         verdict_type want;
         if (pending_verdicts.size() == 0) begin
            $error("unexpected verdict col %0d row %0d", got.col, got.row);
            errors++;
            return;
         end
         want = pending_verdicts.pop_front();
         checked++;
         if (want.frontier) frontiers++;
         if (got.col !== want.col) begin
            $error("cell_col expected %0d actual %0d", want.col, got.col);
            errors++;
         end
         if (got.row !== want.row) begin
            $error("cell_row expected %0d actual %0d", want.row, got.row);
            errors++;
         end
         if (got.frontier !== want.frontier) begin
            $error("is_frontier expected %0b actual %0b", want.frontier, got.frontier);
            errors++;
         end
         if (got.last !== want.last) begin
            $error("last_cell expected %0b actual %0b", want.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   fcd_req_if req_bus ();
   fcd_rsp_if rsp_bus ();
   fcd_csr_if csr_bus ();

   frontier_cell_detector dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   frontier_scoreboard board = new();

   int unsigned src_idle_pct = 0;
   int unsigned snk_stall_pct = 0;
   bit          hold_armed = 0;
   bit          rsp_hold = 0;
   int unsigned live_requests = 0;
   int unsigned maps_run = 0;

   always #5 clock = ~clock;

   initial begin
      #(5_000_000);
      $display("TEST FAILED");
      $finish;
   end

   // long receiver hold-off, counted on rising edges
   initial begin
      wait (hold_armed);
      @(posedge clock);
      rsp_hold = 1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold = 0;
   end

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= !rsp_hold && ($urandom_range(99) >= snk_stall_pct);
      end
   end

   always @(posedge clock) begin : rsp_monitor
      verdict_type seen;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen.col      = rsp_bus.cell_col;
         seen.row      = rsp_bus.cell_row;
         seen.frontier = rsp_bus.is_frontier;
         seen.last     = rsp_bus.last_cell;
         board.compare_verdict(seen);
      end
   end

   function automatic cell_value_type random_value();
      case ($urandom_range(9))
         0, 1, 2: return CELL_UNKNOWN;
         3, 4, 5: return CELL_FREE;
         6, 7:    return cell_value_type'($urandom_range(1, 100));
         default: return cell_value_type'($urandom);
      endcase
   endfunction

   task automatic set_phase(int unsigned p);
      case (p)
         0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
         1: begin src_idle_pct = 45; snk_stall_pct = 0;  end
         2: begin src_idle_pct = 0;  snk_stall_pct = 45; end
         default: begin src_idle_pct = 6; snk_stall_pct = 6; end
      endcase
   endtask

   task automatic send_req(command_type cmd, cell_value_type val);
      while ($urandom_range(99) < src_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.command    <= cmd;
      req_bus.cell_value <= val;
      do @(posedge clock); while (!req_bus.ready);
      board.accept_request(cmd, val);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (board.pending_verdicts.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_csr(reg_index_type idx, cfg_data_type d);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= d;
      do @(posedge clock); while (!csr_bus.ready);
      board.apply_csr(idx, d);
      @(negedge clock);
   endtask

   task automatic configure(cfg_data_type w, cfg_data_type h);
      wait_idle();
      write_csr(REG_MAP_WIDTH, w);
      write_csr(REG_MAP_HEIGHT, h);
      csr_bus.valid <= 1'b0;
   endtask

   // cut < w*h abandons the map part way through
   task automatic run_map(int unsigned w, int unsigned h, int unsigned noise_pct,
                          int unsigned cut);
      for (int unsigned k = 0; k < cut; k++) begin
         if ($urandom_range(99) < noise_pct) send_req(CMD_FLUSH, random_value());
         send_req(CMD_CELL, random_value());
         live_requests++;
      end
      maps_run++;
      if (cut < w * h) return;
      for (int unsigned k = 0; k <= w; k++) begin
         if ($urandom_range(99) < noise_pct) send_req(CMD_CELL, random_value());
         else send_req(CMD_FLUSH, random_value());
         live_requests++;
      end
   endtask

   initial begin
      cell_value_type grid[9];
      cfg_data_type   w_val, h_val;
      int unsigned    w, h, kind, map_idx, k;
      bit             force_cfg;

      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.command    = CMD_CELL;
      req_bus.cell_value = '0;
      csr_bus.valid      = 1'b0;
      csr_bus.index      = REG_MAP_WIDTH;
      csr_bus.data       = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // 3x3 map: value extremes, early flush, cell during drain, flush after end
      grid = '{CELL_FREE, CELL_UNKNOWN, CELL_FREE,
               CELL_FREE, CELL_FREE, 8'sd100,
               -8'sd128, 8'sd127, CELL_FREE};
      configure(11'd3, 11'd3);
      send_req(CMD_FLUSH, 8'sd0);
      for (k = 0; k < 9; k++) begin
         send_req(CMD_CELL, grid[k]);
         if (k == 3) send_req(CMD_FLUSH, -8'sd1);
      end
      send_req(CMD_FLUSH, 8'sd0);
      send_req(CMD_CELL, CELL_UNKNOWN);
      send_req(CMD_FLUSH, 8'sd1);
      send_req(CMD_FLUSH, 8'sd0);
      send_req(CMD_FLUSH, 8'sd0);

      // zero width and height act as one
      configure(11'd0, 11'd0);
      send_req(CMD_CELL, CELL_FREE);
      send_req(CMD_FLUSH, 8'sd0);
      send_req(CMD_FLUSH, 8'sd0);
      configure(11'd2, 11'd1);
      send_req(CMD_CELL, CELL_FREE);
      send_req(CMD_CELL, CELL_UNKNOWN);
      send_req(CMD_FLUSH, 8'sd0);
      send_req(CMD_FLUSH, 8'sd0);
      send_req(CMD_FLUSH, 8'sd0);

      // oversized width clamps to the maximum: first verdicts show up in row 1
      set_phase(0);
      configure(11'h7FF, 11'h7FF);
      run_map(MAX_DIM, MAX_DIM, 0, MAX_DIM + 8);

      live_requests = 0;
      map_idx = 0;
      force_cfg = 1;
      w_val = 11'd1;
      h_val = 11'd1;
      while (live_requests < RANDOM_REQUESTS || map_idx < 4) begin
         set_phase(map_idx % 4);
         if (map_idx == 0) begin
            set_phase(0);
            w_val = 11'd16;
            h_val = 11'd6;
            configure(w_val, h_val);
            hold_armed = 1;
         end else if (force_cfg || $urandom_range(2) != 0) begin
            case ($urandom_range(7))
               0: w_val = 11'd0;
               1: w_val = 11'd1;
               2: w_val = 11'd2;
               default: w_val = cfg_data_type'($urandom_range(3, 12));
            endcase
            case ($urandom_range(7))
               0: h_val = 11'd0;
               1: h_val = 11'd1;
               2: h_val = 11'd2;
               default: h_val = cfg_data_type'($urandom_range(3, 8));
            endcase
            configure(w_val, h_val);
         end
         force_cfg = 0;
         w = frontier_scoreboard::clamp_dim(w_val);
         h = frontier_scoreboard::clamp_dim(h_val);
         kind = $urandom_range(9);
         if (kind == 0 && map_idx != 0) begin
            run_map(w, h, 10, $urandom_range(w * h - 1));
            force_cfg = 1;
         end else begin
            run_map(w, h, (kind == 1) ? 20 : 3, w * h);
         end
         map_idx++;
      end

      req_bus.valid <= 1'b0;
      for (k = 0; k < 5000 && board.pending_verdicts.size() != 0; k++) @(negedge clock);
      repeat (20) @(negedge clock);
      if (board.pending_verdicts.size() != 0) begin
         $error("%0d verdicts never arrived", board.pending_verdicts.size());
         board.errors++;
      end

      $display("Ran %0d maps, sizes 1x1 up to a clamped 1024-wide one, under four idle mixes",
               maps_run);
      $display("Checked %0d verdicts, %0d of them frontier cells", board.checked,
               board.frontiers);
      if (board.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
